[hdl/jmbd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmbd_pkg
// shared widths and constants of the median jet background density unit
// ----------------------------------------------------------------------------
package jmbd_pkg;

  localparam int MAX_JETS_DEF = 1024;
  localparam int MOM_W        = 20;
  localparam int AREA_W       = 16;
  localparam int RHO_W        = 20;
  localparam int CNT_OUT_W    = 11;
  localparam int EXCL_W       = 2;
  localparam int FRAC_SHIFT   = 12;
  // nonnegative momentum magnitude bits, shifted up by the area fraction
  localparam int DIV_W        = MOM_W - 1 + FRAC_SHIFT;
  localparam logic [RHO_W-1:0] RHO_MAX = {RHO_W{1'b1}};

endpackage

[hdl/jet_median_background_density_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_median_background_density_unit
// median momentum-per-area of one jet collection, memory based
// ----------------------------------------------------------------------------
// load: one jet item per cycle, busy stays low until the item marked last_jet
// finish: a read and a check per stored jet, plus the serial divider when
//   it enters the median with nonzero area; median search of RW bit passes,
//   twice that for an even count; then the strobe, ready the cycle after
// synchronous active-low reset clears the control state and the register;
//   memories hold no reset value, only current entries are read; no stalls
module jet_median_background_density_unit #(
  parameter int MAX_JETS = jmbd_pkg::MAX_JETS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // item channel
  input  logic                             start,
  output logic                             busy,
  input  logic signed [jmbd_pkg::MOM_W-1:0] in_jet_momentum,
  input  logic [jmbd_pkg::AREA_W-1:0]      in_jet_area,
  input  logic                             in_last_jet,
  // result channel
  output logic                             out_valid,
  output logic [jmbd_pkg::RHO_W-1:0]       out_rho_value,
  output logic                             out_rho_found,
  output logic [jmbd_pkg::CNT_OUT_W-1:0]   out_accepted_count,
  // configuration
  input  logic                             cfg_we,
  input  logic [jmbd_pkg::EXCL_W-1:0]      cfg_exclude_leading_count
);

  localparam int AW  = $clog2(MAX_JETS);
  localparam int CW  = $clog2(MAX_JETS + 1);
  localparam int MW  = jmbd_pkg::MOM_W;
  localparam int ARW = jmbd_pkg::AREA_W;
  localparam int RW  = jmbd_pkg::RHO_W;
  localparam int BW  = $clog2(RW);

  typedef enum logic [2:0] {
    S_LOAD, S_RD, S_CHK, S_DIV, S_SEL, S_CNT, S_OUT
  } state_t;

  state_t state_r;

  // configuration register
  logic [jmbd_pkg::EXCL_W-1:0] excl_cfg_r;
  // exclusion latched at the last item
  logic ex1_r, ex2_r;

  // collection state
  logic [CW-1:0]        cnt_r;
  logic                 lv0_r, lv1_r;
  logic [AW-1:0]        li0_r, li1_r;
  logic signed [MW-1:0] lm0_r, lm1_r;

  // scan state
  logic [CW-1:0] i_r;
  logic [CW-1:0] n_r;

  // median search state
  logic [CW-1:0] j_r;
  logic          pvld_r;
  logic [CW-1:0] lt_r;
  logic [CW-1:0] k_r;
  logic [BW-1:0] bit_r;
  logic [RW-1:0] r_r;
  logic [RW-1:0] lo_r;
  logic          pass_r;

  // result registers
  logic          ov_r;
  logic [RW-1:0] rho_r;
  logic          found_r;
  logic [CW-1:0] acc_r;

  // memories
  logic [MW+ARW-1:0] jet_mem [MAX_JETS];
  logic [RW-1:0]     ratio_mem [MAX_JETS];
  logic [MW+ARW-1:0] jet_rd_r;
  logic [RW-1:0]     ratio_rd_r;

  logic               accept;
  logic               store_en;
  logic               jet_we;
  logic [AW-1:0]      jet_addr;
  logic               ratio_we;
  logic [AW-1:0]      ratio_waddr;
  logic [RW-1:0]      ratio_wdata;

  // divider
  logic                       div_start;
  logic                       div_done;
  logic [jmbd_pkg::DIV_W-1:0] div_quo;

  logic signed [MW-1:0] rd_mom;
  logic [ARW-1:0]       rd_area;
  logic                 rd_excl;
  logic [RW-1:0]        cand;
  logic [RW-1:0]        r_upd;
  logic [RW:0]          mid_sum;
  logic                 even_n;
  logic [CW-1:0]        half_n;
  logic [RW-1:0]        sat_quo;
  logic [CW+jmbd_pkg::CNT_OUT_W-1:0] acc_ext;

  assign busy     = (state_r != S_LOAD);
  assign accept   = start && !busy;
  assign store_en = cnt_r < CW'(MAX_JETS);

  assign rd_mom  = jet_rd_r[MW+ARW-1:ARW];
  assign rd_area = jet_rd_r[ARW-1:0];
  assign rd_excl = (ex1_r && lv0_r && (i_r[AW-1:0] == li0_r)) ||
                   (ex2_r && lv1_r && (i_r[AW-1:0] == li1_r));

  // quotient saturates to the top of the rho range
  assign sat_quo = (div_quo > {{(jmbd_pkg::DIV_W-RW){1'b0}}, jmbd_pkg::RHO_MAX}) ?
                   jmbd_pkg::RHO_MAX : div_quo[RW-1:0];

  assign div_start = (state_r == S_CHK) && !rd_excl && !rd_mom[MW-1] && (rd_area != '0);

  // jet memory: write while loading, read during the scan
  assign jet_we   = accept && store_en;
  assign jet_addr = (state_r == S_LOAD) ? cnt_r[AW-1:0] : i_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (jet_we) begin
      jet_mem[jet_addr] <= {in_jet_momentum, in_jet_area};
    end
    jet_rd_r <= jet_mem[jet_addr];
  end

  // ratio memory: appended during the scan, swept by the median search
  always_comb begin
    ratio_we    = 1'b0;
    ratio_waddr = n_r[AW-1:0];
    ratio_wdata = sat_quo;
    if (state_r == S_CHK && !rd_excl && !rd_mom[MW-1] && rd_area == '0) begin
      ratio_we    = 1'b1;
      ratio_wdata = jmbd_pkg::RHO_MAX;
    end else if (state_r == S_DIV && div_done) begin
      ratio_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ratio_we) begin
      ratio_mem[ratio_waddr] <= ratio_wdata;
    end
    ratio_rd_r <= ratio_mem[j_r[AW-1:0]];
  end

  jmbd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({rd_mom[MW-2:0], {jmbd_pkg::FRAC_SHIFT{1'b0}}}),
    .divisor  (rd_area),
    .done     (div_done),
    .quotient (div_quo)
  );

  // median search helpers: keep the candidate bit if at most k ratios lie below
  assign cand    = r_r | (RW'(1) << bit_r);
  assign r_upd   = (lt_r <= k_r) ? cand : r_r;
  assign mid_sum = {1'b0, lo_r} + {1'b0, r_upd};
  assign even_n  = !n_r[0];
  assign half_n  = n_r >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      excl_cfg_r <= '0;
      ex1_r      <= 1'b0;
      ex2_r      <= 1'b0;
      cnt_r      <= '0;
      lv0_r      <= 1'b0;
      lv1_r      <= 1'b0;
      lm0_r      <= '0;
      lm1_r      <= '0;
      i_r        <= '0;
      n_r        <= '0;
      j_r        <= '0;
      pvld_r     <= 1'b0;
      lt_r       <= '0;
      pass_r     <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      if (cfg_we) begin
        excl_cfg_r <= cfg_exclude_leading_count;
      end
      unique case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (store_en) begin
              cnt_r <= cnt_r + 1'b1;
              // leading pair, strictly positive momenta, earlier wins ties
              if (in_jet_momentum > lm0_r) begin
                lm1_r <= lm0_r;
                li1_r <= li0_r;
                lv1_r <= lv0_r;
                lm0_r <= in_jet_momentum;
                li0_r <= cnt_r[AW-1:0];
                lv0_r <= 1'b1;
              end else if (in_jet_momentum > lm1_r) begin
                lm1_r <= in_jet_momentum;
                li1_r <= cnt_r[AW-1:0];
                lv1_r <= 1'b1;
              end
            end
            if (in_last_jet) begin
              // a register value of three drops two jets
              ex1_r   <= (cfg_we ? cfg_exclude_leading_count : excl_cfg_r) != '0;
              ex2_r   <= (cfg_we ? cfg_exclude_leading_count[1] : excl_cfg_r[1]);
              i_r     <= '0;
              n_r     <= '0;
              state_r <= S_RD;
            end
          end
        end
        S_RD: begin
          // read of entry i is issued through jet_addr
          state_r <= (i_r == cnt_r) ? S_SEL : S_CHK;
          if (i_r == cnt_r) begin
            pass_r <= 1'b0;
            bit_r  <= BW'(RW - 1);
            r_r    <= '0;
            k_r    <= n_r[0] ? half_n : half_n - 1'b1;
          end
        end
        S_CHK: begin
          if (rd_excl || rd_mom[MW-1]) begin
            i_r     <= i_r + 1'b1;
            state_r <= S_RD;
          end else if (rd_area == '0) begin
            n_r     <= n_r + 1'b1;
            i_r     <= i_r + 1'b1;
            state_r <= S_RD;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            n_r     <= n_r + 1'b1;
            i_r     <= i_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_SEL: begin
          if (n_r == '0) begin
            rho_r   <= '0;
            found_r <= 1'b0;
            acc_r   <= '0;
            ov_r    <= 1'b1;
            state_r <= S_OUT;
          end else begin
            j_r     <= '0;
            pvld_r  <= 1'b0;
            lt_r    <= '0;
            state_r <= S_CNT;
          end
        end
        S_CNT: begin
          // one read issued and one ratio counted per cycle
          pvld_r <= (j_r != n_r);
          if (j_r != n_r) begin
            j_r <= j_r + 1'b1;
          end
          if (pvld_r && ratio_rd_r < cand) begin
            lt_r <= lt_r + 1'b1;
          end
          if (j_r == n_r && !pvld_r) begin
            if (bit_r != '0) begin
              r_r     <= r_upd;
              bit_r   <= bit_r - 1'b1;
              state_r <= S_SEL;
            end else if (even_n && !pass_r) begin
              // lower middle done, search the upper one
              lo_r    <= r_upd;
              pass_r  <= 1'b1;
              r_r     <= '0;
              bit_r   <= BW'(RW - 1);
              k_r     <= half_n;
              state_r <= S_SEL;
            end else begin
              rho_r   <= even_n ? mid_sum[RW:1] : r_upd;
              found_r <= 1'b1;
              acc_r   <= n_r;
              ov_r    <= 1'b1;
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          // result strobe is out, clear for the next collection
          cnt_r   <= '0;
          lv0_r   <= 1'b0;
          lv1_r   <= 1'b0;
          lm0_r   <= '0;
          lm1_r   <= '0;
          state_r <= S_LOAD;
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign acc_ext            = {{jmbd_pkg::CNT_OUT_W{1'b0}}, acc_r};
  assign out_valid          = ov_r;
  assign out_rho_value      = rho_r;
  assign out_rho_found      = found_r;
  assign out_accepted_count = acc_ext[jmbd_pkg::CNT_OUT_W-1:0];

endmodule

[hdl/jmbd_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmbd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module jmbd_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [jmbd_pkg::DIV_W-1:0]   dividend,
  input  logic [jmbd_pkg::AREA_W-1:0]  divisor,
  output logic                         done,
  output logic [jmbd_pkg::DIV_W-1:0]   quotient
);

  localparam int SW = $clog2(jmbd_pkg::DIV_W);

  logic                          run_r;
  logic                          done_r;
  logic [SW-1:0]                 step_r;
  logic [jmbd_pkg::AREA_W-1:0]   rem_r;
  logic [jmbd_pkg::DIV_W-1:0]    quo_r;
  logic [jmbd_pkg::AREA_W-1:0]   dvs_r;
  logic [jmbd_pkg::AREA_W:0]     trial;
  logic [jmbd_pkg::AREA_W:0]     diff;
  logic                          ge;

  assign trial = {rem_r, quo_r[jmbd_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        if (step_r == SW'(jmbd_pkg::DIV_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (run_r) begin
      rem_r <= ge ? diff[jmbd_pkg::AREA_W-1:0] : trial[jmbd_pkg::AREA_W-1:0];
      quo_r <= {quo_r[jmbd_pkg::DIV_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
